/* rtl/keymatrix_modifier_translator_core_defines.svh */
// Assertion macros shared by the keymatrix translator RTL.
`ifndef KEYMATRIX_MODIFIER_TRANSLATOR_CORE_DEFINES_SVH
`define KEYMATRIX_MODIFIER_TRANSLATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmt assertion failed");

`endif

/* rtl/kmt_pkg.sv */
// Types, keymaps and constants of the keymatrix translator.
package kmt_pkg;

    localparam int MAX_KEYS = 4;
    localparam int ROWS     = 4;
    localparam int COLS     = 10;

    localparam logic [1:0] MOD_ROW   = 2'd2;
    localparam logic [3:0] SYM_COL   = 4'd0;
    localparam logic [3:0] SHIFT_COL = 4'd8;

    localparam logic REG_BACKLIGHT_PEAK  = 1'b0;
    localparam logic REG_BACKLIGHT_FLOOR = 1'b1;

    localparam logic [7:0] PEAK_RESET  = 8'd255;
    localparam logic [7:0] FLOOR_RESET = 8'd64;

    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        MAP_LOWER,
        MAP_UPPER,
        MAP_SYMBOL
    } t_map_sel;

    typedef logic [6:0] t_keymap [0:ROWS-1][0:COLS-1];

    localparam t_keymap KEYMAP_LOWER = '{
        '{7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70},
        '{7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h0A},
        '{7'h00, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h00, 7'h08},
        '{7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };

    localparam t_keymap KEYMAP_UPPER = '{
        '{7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50},
        '{7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h0A},
        '{7'h00, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h00, 7'h08},
        '{7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };

    localparam t_keymap KEYMAP_SYMBOL = '{
        '{7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30},
        '{7'h2E, 7'h2F, 7'h2B, 7'h2D, 7'h3D, 7'h3A, 7'h27, 7'h22, 7'h40, 7'h09},
        '{7'h00, 7'h5F, 7'h24, 7'h3B, 7'h3F, 7'h21, 7'h2C, 7'h2E, 7'h00, 7'h08},
        '{7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };

    typedef struct packed {
        logic       action;
        logic [2:0] pressed_count;
        logic [1:0] key_row_0;
        logic [3:0] key_col_0;
        logic [1:0] key_row_1;
        logic [3:0] key_col_1;
        logic [1:0] key_row_2;
        logic [3:0] key_col_2;
        logic [1:0] key_row_3;
        logic [3:0] key_col_3;
        logic       symbol_released;
        logic       shift_released;
    } t_in_item;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic [7:0] backlight_duty;
        logic       last;
    } t_out_item;

    // Classified scan/tick handed from front to back.
    typedef struct packed {
        logic [MAX_KEYS-1:0]      mask;
        logic [MAX_KEYS-1:0][6:0] chars;
        logic [7:0]               duty;
    } t_job;

    function automatic logic [6:0] key_char(t_map_sel sel, logic [1:0] row, logic [3:0] col);
        logic [6:0] c;
        c = '0;
        if (col < 4'(COLS)) begin
            case (sel)
                MAP_SYMBOL: c = KEYMAP_SYMBOL[row][col];
                MAP_UPPER:  c = KEYMAP_UPPER[row][col];
                default:    c = KEYMAP_LOWER[row][col];
            endcase
        end
        return c;
    endfunction

endpackage

/* rtl/kmt_fifo.sv */
// Job queue between the classifying front end and the emitting back end.
`include "keymatrix_modifier_translator_core_defines.svh"

module kmt_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kmt_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output kmt_pkg::t_job o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kmt_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `KMT_ASSERT_IMPLIES(a_pop_not_empty, i_clk, i_rst_n, i_pop, r_count != '0)
    `KMT_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)
    `KMT_ASSERT_NEXT(a_pop_shrinks, i_clk, i_rst_n, i_pop && !i_push, r_count == $past(r_count) - 1'b1)

endmodule

/* rtl/kmt_front.sv */
// Front end: takes transactions, updates modifiers and duty, builds jobs.
module kmt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  kmt_pkg::t_in_item i_in_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_queue_full,
    output logic             o_push,
    output kmt_pkg::t_job    o_job
);

    logic [7:0] r_peak, n_peak;
    logic [7:0] r_floor, n_floor;
    logic       r_sym, n_sym;
    logic       r_shift, n_shift;
    logic       r_caps, n_caps;
    logic       r_armed, n_armed;
    logic [7:0] r_duty, n_duty;

    logic [1:0]                rows [kmt_pkg::MAX_KEYS];
    logic [3:0]                cols [kmt_pkg::MAX_KEYS];
    logic [2:0]                count_sat;
    logic [kmt_pkg::MAX_KEYS-1:0] slot_en;
    logic                      sym_hit, shift_hit, sym1, shift1, toggle, caps1, armed1;
    logic                      sym2, shift2;
    kmt_pkg::t_map_sel         sel;
    logic [6:0]                ch;

    assign rows[0] = i_in_data.key_row_0;
    assign rows[1] = i_in_data.key_row_1;
    assign rows[2] = i_in_data.key_row_2;
    assign rows[3] = i_in_data.key_row_3;
    assign cols[0] = i_in_data.key_col_0;
    assign cols[1] = i_in_data.key_col_1;
    assign cols[2] = i_in_data.key_col_2;
    assign cols[3] = i_in_data.key_col_3;

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        count_sat = (i_in_data.pressed_count > 3'(kmt_pkg::MAX_KEYS))
                  ? 3'(kmt_pkg::MAX_KEYS) : i_in_data.pressed_count;
        sym_hit   = 1'b0;
        shift_hit = 1'b0;
        for (int i = 0; i < kmt_pkg::MAX_KEYS; i++) begin
            slot_en[i] = (3'(i) < count_sat);
            if (slot_en[i] && rows[i] == kmt_pkg::MOD_ROW && cols[i] == kmt_pkg::SYM_COL) begin
                sym_hit = 1'b1;
            end
            if (slot_en[i] && rows[i] == kmt_pkg::MOD_ROW && cols[i] == kmt_pkg::SHIFT_COL) begin
                shift_hit = 1'b1;
            end
        end
        sym1   = r_sym || sym_hit;
        shift1 = r_shift || shift_hit;
        toggle = sym1 && shift1 && r_armed;
        caps1  = r_caps ^ toggle;
        armed1 = r_armed && !toggle;

        if (sym1) begin
            sel = kmt_pkg::MAP_SYMBOL;
        end else if (shift1 || caps1) begin
            sel = kmt_pkg::MAP_UPPER;
        end else begin
            sel = kmt_pkg::MAP_LOWER;
        end

        // Releases land after translation; toggle rearms with both keys up.
        sym2   = sym1 && !i_in_data.symbol_released;
        shift2 = shift1 && !i_in_data.shift_released;

        o_job = '0;
        n_sym   = r_sym;
        n_shift = r_shift;
        n_caps  = r_caps;
        n_armed = r_armed;
        n_duty  = r_duty;
        ch      = '0;

        if (i_in_data.action == kmt_pkg::ACT_TICK) begin
            if (r_duty > r_floor) begin
                n_duty = r_duty - 1'b1;
            end
        end else begin
            for (int i = 0; i < kmt_pkg::MAX_KEYS; i++) begin
                ch = slot_en[i] ? kmt_pkg::key_char(sel, rows[i], cols[i]) : 7'd0;
                o_job.chars[i] = ch;
                o_job.mask[i]  = (ch != 7'd0);
            end
            n_sym   = sym2;
            n_shift = shift2;
            n_caps  = caps1;
            n_armed = armed1 || (!sym2 && !shift2);
            if (count_sat != 3'd0) begin
                n_duty = r_peak;
            end
        end
        o_job.duty = n_duty;

        if (!o_push) begin
            n_sym   = r_sym;
            n_shift = r_shift;
            n_caps  = r_caps;
            n_armed = r_armed;
            n_duty  = r_duty;
        end

        n_peak  = r_peak;
        n_floor = r_floor;
        if (i_cfg_we) begin
            case (i_cfg_index)
                kmt_pkg::REG_BACKLIGHT_PEAK:  n_peak  = i_cfg_data;
                kmt_pkg::REG_BACKLIGHT_FLOOR: n_floor = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= kmt_pkg::PEAK_RESET;
            r_floor <= kmt_pkg::FLOOR_RESET;
            r_sym   <= 1'b0;
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_armed <= 1'b1;
            r_duty  <= 8'd0;
        end else begin
            r_peak  <= n_peak;
            r_floor <= n_floor;
            r_sym   <= n_sym;
            r_shift <= n_shift;
            r_caps  <= n_caps;
            r_armed <= n_armed;
            r_duty  <= n_duty;
        end
    end

endmodule

/* rtl/kmt_back.sv */
// Back end: walks each job's characters and drives the result register.
`include "keymatrix_modifier_translator_core_defines.svh"

module kmt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  kmt_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output kmt_pkg::t_out_item o_out_data
);

    logic                         r_busy, n_busy;
    logic [kmt_pkg::MAX_KEYS-1:0] r_mask, n_mask;
    logic [kmt_pkg::MAX_KEYS-1:0][6:0] r_chars, n_chars;
    logic [7:0]                   r_duty, n_duty;
    logic                         r_out_valid, n_out_valid;
    kmt_pkg::t_out_item           r_out, n_out;

    logic                         can_emit, emit, job_done;
    logic [kmt_pkg::MAX_KEYS-1:0] lowest, rem;
    logic [6:0]                   code;

    assign can_emit = !r_out_valid || i_out_ready;
    assign emit     = r_busy && can_emit;
    assign lowest   = r_mask & (~r_mask + 1'b1);
    assign rem      = r_mask & ~lowest;
    assign job_done = emit && (rem == '0);
    assign o_pop    = i_job_valid && (!r_busy || job_done);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        code = '0;
        for (int i = 0; i < kmt_pkg::MAX_KEYS; i++) begin
            if (lowest[i]) begin
                code = code | r_chars[i];
            end
        end

        n_busy      = r_busy;
        n_mask      = r_mask;
        n_chars     = r_chars;
        n_duty      = r_duty;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (emit) begin
            // Empty mask gives the single no-character result.
            n_out.char_valid     = (r_mask != '0);
            n_out.char_code      = code;
            n_out.backlight_duty = r_duty;
            n_out.last           = (rem == '0);
            n_out_valid          = 1'b1;
            n_mask               = rem;
        end
        if (job_done) begin
            n_busy = 1'b0;
        end
        if (o_pop) begin
            n_busy  = 1'b1;
            n_mask  = i_job.mask;
            n_chars = i_job.chars;
            n_duty  = i_job.duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask  <= n_mask;
        r_chars <= n_chars;
        r_duty  <= n_duty;
        r_out   <= n_out;
    end

    `KMT_ASSERT_IMPLIES(a_empty_is_last, i_clk, i_rst_n, r_out_valid && !r_out.char_valid, r_out.last)
    `KMT_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_busy)
    `KMT_ASSERT_NEXT(a_done_idles, i_clk, i_rst_n, job_done && !o_pop, !r_busy)

endmodule

/* rtl/keymatrix_modifier_translator_core.sv */
// Path: job queue, back-end job registers, result register. Throughput: a transaction
// is taken every cycle while the job queue has room; the back end drives one result
// per cycle while the result channel takes it, and a scan gives max(characters, 1)
// results. The single result register and the back end's walk set the rate.
// Reset (i_rst_n low, synchronous): modifiers clear, caps toggle arms, duty 0,
// peak 255, floor 64, queue and result register empty.
module keymatrix_modifier_translator_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kmt_pkg::t_in_item  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kmt_pkg::t_out_item o_out_data,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    // Front to queue
    logic          push;
    logic          queue_full;
    kmt_pkg::t_job push_job;

    // Queue to back
    logic          pop;
    logic          job_valid;
    kmt_pkg::t_job pop_job;

    // Front end: applies the whole transaction to the modifier, caps-lock and duty
    // state at acceptance, so the job carries final duty and translated characters.
    kmt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Short job queue decouples scan intake from result drain.
    kmt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (pop_job)
    );

    // Back end: one result per non-null character in slot order, or a single
    // empty result; next job is loaded in the cycle the last result issues.
    kmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
